[src/two_stack_line_editor_assert.svh]
// Assertion macros for the line editor; clk and rst_n must be in scope.
`ifndef TWO_STACK_LINE_EDITOR_ASSERT_SVH
`define TWO_STACK_LINE_EDITOR_ASSERT_SVH

// Condition holds at every edge out of reset.
`define TSLE_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("line editor check failed");

// Antecedent implies consequent in the same cycle.
`define TSLE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line editor check failed");

`endif

[src/tsle_pkg.sv]
`timescale 1ns / 1ps

package tsle_pkg;

    localparam int LINE_CAPACITY = 256;
    localparam int CHAR_W        = 8;

    typedef enum logic [2:0] {
        F_INSERT    = 3'd0,
        F_OVERWRITE = 3'd1,
        F_DEL_PREV  = 3'd2,
        F_DEL_CUR   = 3'd3,
        F_RIGHT     = 3'd4,
        F_LEFT      = 3'd5,
        F_END       = 3'd6,
        F_START     = 3'd7
    } func_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        func_t             func;
        logic [CHAR_W-1:0] char_in;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [CHAR_W-1:0] cursor_char;
        logic              cursor_valid;
        logic [8:0]        line_length;
    } rsp_t;

endpackage

[src/tsle_stream_if.sv]
`timescale 1ns / 1ps

interface tsle_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/tsle_store.sv]
`timescale 1ns / 1ps

module tsle_store #(
    parameter int DEPTH = tsle_pkg::LINE_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [tsle_pkg::CHAR_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [tsle_pkg::CHAR_W-1:0] rd_data
);

    logic [tsle_pkg::CHAR_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/two_stack_line_editor.sv]
// Line editor with a cursor, kept as a gap buffer in one memory.
// req carries one command (func, char_in); rsp returns one result per command:
// status, the character at the cursor with its valid flag, and the line length.
// Characters before the cursor fill the memory upward from entry 0; characters
// from the cursor on fill it downward from the top entry.
// Insert, overwrite, delete before the cursor, any error and a jump with nothing
// to move go from idle straight to the result state; a left move passes through
// S_LFILL, and delete at cursor or a right move that leaves a character at the
// cursor passes through S_RFETCH, to read the new cursor character. A jump moves
// its characters one at a time, to the end from idle on through S_RFETCH and to
// the start through S_LFILL. The jump cost is set by the single read and single
// write port of the line memory, one character per cycle. One request is in work
// at a time; req.ready is high only while idle.
// Reset empties the line and puts the cursor at the start; the memory itself
// is not cleared, entries are only read after they are written.
// A result waits in an output register while rsp.ready is low; the block takes
// and finishes the next request meanwhile, then holds until that slot frees.
// An insert into a full line, or an overwrite, a one-step move or a delete with
// nothing to act on, returns an error status and leaves the line unchanged.
`timescale 1ns / 1ps

`include "two_stack_line_editor_assert.svh"

module two_stack_line_editor #(
    parameter int LINE_CAPACITY = tsle_pkg::LINE_CAPACITY
) (
    input  logic          clk,
    input  logic          rst_n,
    tsle_stream_if.sink   req,
    tsle_stream_if.source rsp
);

    localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam int CW = $clog2(LINE_CAPACITY + 1);
    localparam int TW = CW + 9;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LFILL  = 4'b0010,
        S_RFETCH = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    localparam logic [CW-1:0] CAP = CW'(LINE_CAPACITY);
    localparam logic [CW-1:0] ONE = CW'(1);

    state_t                      state_reg, state_next;
    logic [CW-1:0]               before_reg, before_next;
    logic [CW-1:0]               after_reg, after_next;
    logic [tsle_pkg::CHAR_W-1:0] cursor_reg, cursor_next;
    tsle_pkg::func_t             func_reg, func_next;
    logic [1:0]                  status_reg, status_next;
    logic                        out_valid_reg, out_valid_next;
    tsle_pkg::rsp_t              out_data_reg, out_data_next;

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [tsle_pkg::CHAR_W-1:0] wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [tsle_pkg::CHAR_W-1:0] rd_data;

    logic [TW-1:0]               total;
    logic [CW-1:0]               top_idx;
    logic [CW-1:0]               next_top_idx;
    logic [CW-1:0]               below_top_idx;
    logic [CW-1:0]               prev_idx;
    logic [CW-1:0]               prev2_idx;

    assign total         = TW'(before_reg) + TW'(after_reg);
    assign top_idx       = CAP - after_reg;
    assign next_top_idx  = top_idx + ONE;
    assign below_top_idx = top_idx - ONE;
    assign prev_idx      = before_reg - ONE;
    assign prev2_idx     = prev_idx - ONE;

    tsle_store #(
        .DEPTH (LINE_CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        before_next    = before_reg;
        after_next     = after_reg;
        cursor_next    = cursor_reg;
        func_next      = func_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = before_reg[AW-1:0];
        wr_data        = cursor_reg;
        rd_en          = 1'b0;
        rd_addr        = next_top_idx[AW-1:0];

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next   = req.data.func;
                    status_next = tsle_pkg::ST_OK;
                    state_next  = S_DONE;
                    unique case (req.data.func)
                        tsle_pkg::F_INSERT:
                        begin
                            if (total >= TW'(LINE_CAPACITY))
                            begin
                                status_next = tsle_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                wr_data     = req.data.char_in;
                                before_next = before_reg + ONE;
                            end
                        end
                        tsle_pkg::F_OVERWRITE:
                        begin
                            if (before_reg == '0)
                            begin
                                status_next = tsle_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = prev_idx[AW-1:0];
                                wr_data = req.data.char_in;
                            end
                        end
                        tsle_pkg::F_DEL_PREV:
                        begin
                            if (before_reg == '0)
                            begin
                                status_next = tsle_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                before_next = prev_idx;
                            end
                        end
                        tsle_pkg::F_DEL_CUR:
                        begin
                            if (after_reg == '0)
                            begin
                                status_next = tsle_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                after_next = after_reg - ONE;
                                if (after_reg > ONE)
                                begin
                                    rd_en      = 1'b1;
                                    state_next = S_RFETCH;
                                end
                            end
                        end
                        tsle_pkg::F_RIGHT, tsle_pkg::F_END:
                        begin
                            if (after_reg == '0)
                            begin
                                if (req.data.func == tsle_pkg::F_RIGHT)
                                begin
                                    status_next = tsle_pkg::ST_EMPTY;
                                end
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                before_next = before_reg + ONE;
                                after_next  = after_reg - ONE;
                                if (after_reg > ONE)
                                begin
                                    rd_en      = 1'b1;
                                    state_next = S_RFETCH;
                                end
                            end
                        end
                        tsle_pkg::F_LEFT, tsle_pkg::F_START:
                        begin
                            if (before_reg == '0)
                            begin
                                if (req.data.func == tsle_pkg::F_LEFT)
                                begin
                                    status_next = tsle_pkg::ST_EMPTY;
                                end
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = prev_idx[AW-1:0];
                                state_next = S_LFILL;
                            end
                        end
                    endcase
                end
            end

            S_LFILL:
            begin
                wr_en       = 1'b1;
                wr_addr     = below_top_idx[AW-1:0];
                wr_data     = rd_data;
                cursor_next = rd_data;
                before_next = prev_idx;
                after_next  = after_reg + ONE;
                if (func_reg == tsle_pkg::F_START && before_reg > ONE)
                begin
                    rd_en   = 1'b1;
                    rd_addr = prev2_idx[AW-1:0];
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_RFETCH:
            begin
                if (func_reg == tsle_pkg::F_END)
                begin
                    wr_en       = 1'b1;
                    wr_data     = rd_data;
                    before_next = before_reg + ONE;
                    after_next  = after_reg - ONE;
                    if (after_reg > ONE)
                    begin
                        rd_en = 1'b1;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cursor_next = rd_data;
                    state_next  = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.status       = status_reg;
                    out_data_next.cursor_valid = (after_reg != '0);
                    out_data_next.cursor_char  = (after_reg != '0) ? cursor_reg : '0;
                    out_data_next.line_length  = total[8:0];
                    state_next                 = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            before_reg    <= '0;
            after_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            before_reg    <= before_next;
            after_reg     <= after_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_reg   <= cursor_next;
        func_reg     <= func_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    `TSLE_ASSERT_ALWAYS(a_fill_bound, total <= TW'(LINE_CAPACITY))
    `TSLE_ASSERT_IMP(a_port_conflict, wr_en && rd_en, wr_addr != rd_addr)
    `TSLE_ASSERT_IMP(a_lfill_src, state_reg == S_LFILL, before_reg != '0)
    `TSLE_ASSERT_IMP(a_rfetch_src, state_reg == S_RFETCH, after_reg != '0)

endmodule
